// ===== rtl/lkvc_pkg.sv =====
// Shared types for the LRU key-value cache: request codes, sequencer states, cell control.
package lkvc_pkg;

  typedef enum logic [1:0] {
    REQ_GET    = 2'd0,
    REQ_PUT    = 2'd1,
    REQ_REMOVE = 2'd2,
    REQ_CLEAR  = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMP,
    ST_UPD
  } state_e;

  // Broadcast from the sequencer to every cell of the chain
  typedef struct packed {
    logic cmp_en;
    logic upd_en;
    req_e req;
    logic hit;
    logic evict;
  } cell_ctl_t;

endpackage

// ===== rtl/lkvc_cell.sv =====
// One slot of the recency-ordered chain: holds one entry and moves it to a neighbour on update.
module lkvc_cell #(
  parameter int KEY_BITS   = 32,
  parameter int VALUE_BITS = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  lkvc_pkg::cell_ctl_t   ctl_i,
  input  logic [KEY_BITS-1:0]   req_key_i,
  input  logic [KEY_BITS-1:0]   prev_key_i,
  input  logic [VALUE_BITS-1:0] prev_value_i,
  input  logic                  prev_valid_i,
  input  logic [KEY_BITS-1:0]   next_key_i,
  input  logic [VALUE_BITS-1:0] next_value_i,
  input  logic                  next_valid_i,
  input  logic                  pre_i,
  input  logic                  suf_i,
  input  logic [VALUE_BITS-1:0] hv_i,
  output logic [KEY_BITS-1:0]   key_o,
  output logic [VALUE_BITS-1:0] value_o,
  output logic                  valid_o,
  output logic                  pre_o,
  output logic                  suf_o,
  output logic [VALUE_BITS-1:0] hv_o
);

  logic [KEY_BITS-1:0]   key_q;
  logic [VALUE_BITS-1:0] value_q;
  logic                  valid_q, valid_d;
  logic                  match_q, match_d;
  logic                  take_prev, take_next;
  logic                  prev_last;

  assign key_o   = key_q;
  assign value_o = value_q;
  assign valid_o = valid_q;
  assign pre_o   = pre_i | match_q;
  assign suf_o   = suf_i | match_q;
  assign hv_o    = match_q ? value_q : hv_i;

  // previous neighbour is the least recent entry when this slot is empty
  assign prev_last = prev_valid_i & ~valid_q;

  always_comb begin
    take_prev = 1'b0;
    take_next = 1'b0;
    case (ctl_i.req)
      lkvc_pkg::REQ_GET:    take_prev = ctl_i.hit & (match_q | suf_i);
      lkvc_pkg::REQ_PUT:    take_prev = ctl_i.hit ? (match_q | suf_i) : 1'b1;
      lkvc_pkg::REQ_REMOVE: take_next = ctl_i.hit & (pre_i | match_q);
      default: ;
    endcase
  end

  always_comb begin
    valid_d = valid_q;
    match_d = match_q;
    if (ctl_i.cmp_en) begin
      match_d = valid_q & (key_q == req_key_i);
    end
    if (ctl_i.upd_en) begin
      match_d = 1'b0;
      if (ctl_i.req == lkvc_pkg::REQ_CLEAR) begin
        valid_d = 1'b0;
      end else if (take_prev) begin
        // drop the victim as it would slide past the end of the list
        valid_d = prev_valid_i & ~(ctl_i.evict & prev_last);
      end else if (take_next) begin
        valid_d = next_valid_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      match_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
      match_q <= match_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.upd_en && take_prev) begin
      key_q   <= prev_key_i;
      value_q <= prev_value_i;
    end else if (ctl_i.upd_en && take_next) begin
      key_q   <= next_key_i;
      value_q <= next_value_i;
    end
  end

endmodule

// ===== rtl/lru_key_value_cache_unit.sv =====
// Top level of the LRU key-value cache: request sequencer, entry count and the chain of cells.
// Each request goes through a compare and an update state. busy is high for the compare cycle,
// in which every cell checks its key, and for the update cycle, in which the hit, insert or remove
// ripples through the MAX_ENTRIES cells of the chain and every entry moves at most one place. The
// result appears with done_o for one cycle as busy falls, and a new request may be started in
// that same cycle, but not while busy is high. There is no back-pressure: the result word must
// be taken in the one cycle that done_o is high. The ripple across the chain sets the clock rate.
// Entries are kept in recency order, cell 0 being the most recent; reset and clear empty it.
module lru_key_value_cache_unit #(
  parameter int MAX_ENTRIES = 16,
  parameter int KEY_BITS    = 32,
  parameter int VALUE_BITS  = 32
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [1:0]                           req_type_i,
  input  logic [KEY_BITS-1:0]                  key_i,
  input  logic [VALUE_BITS-1:0]                value_in_i,
  input  logic                                 cfg_we_i,
  input  logic [$clog2(MAX_ENTRIES + 1)-1:0]   cfg_wdata_i,
  output logic                                 done_o,
  output logic                                 found_o,
  output logic [VALUE_BITS-1:0]                value_out_o,
  output logic [$clog2(MAX_ENTRIES + 1)-1:0]   entry_count_o
);

  localparam int CntW = $clog2(MAX_ENTRIES + 1);

  lkvc_pkg::state_e      state_q, state_d;
  lkvc_pkg::req_e        req_q;
  logic [KEY_BITS-1:0]   key_q;
  logic [VALUE_BITS-1:0] val_q;
  logic [CntW-1:0]       cap_q;
  logic [CntW-1:0]       count_q, count_d;
  logic [CntW-1:0]       eff_limit;
  logic                  done_q, found_q;
  logic [VALUE_BITS-1:0] vout_q;
  logic                  hit, evict;
  logic [VALUE_BITS-1:0] head_value;
  lkvc_pkg::cell_ctl_t   ctl;

  logic [KEY_BITS-1:0]   c_key [MAX_ENTRIES];
  logic [VALUE_BITS-1:0] c_val [MAX_ENTRIES];
  logic [VALUE_BITS-1:0] c_hv  [MAX_ENTRIES];
  logic [MAX_ENTRIES-1:0] c_valid, c_pre, c_suf;

  assign busy          = (state_q != lkvc_pkg::ST_IDLE);
  assign done_o        = done_q;
  assign found_o       = found_q;
  assign value_out_o   = vout_q;
  assign entry_count_o = count_q;

  assign hit        = c_suf[0];
  assign eff_limit  = (cap_q == '0) ? CntW'(1) :
                      (cap_q > CntW'(MAX_ENTRIES)) ? CntW'(MAX_ENTRIES) : cap_q;
  assign evict      = (req_q == lkvc_pkg::REQ_PUT) & ~hit & (count_q >= eff_limit);
  assign head_value = (req_q == lkvc_pkg::REQ_PUT) ? val_q : c_hv[0];

  always_comb begin
    ctl.cmp_en = (state_q == lkvc_pkg::ST_CMP);
    ctl.upd_en = (state_q == lkvc_pkg::ST_UPD);
    ctl.req    = req_q;
    ctl.hit    = hit;
    ctl.evict  = evict;
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      lkvc_pkg::ST_IDLE: if (start) state_d = lkvc_pkg::ST_CMP;
      lkvc_pkg::ST_CMP:  state_d = lkvc_pkg::ST_UPD;
      lkvc_pkg::ST_UPD:  state_d = lkvc_pkg::ST_IDLE;
      default:           state_d = lkvc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    count_d = count_q;
    case (req_q)
      lkvc_pkg::REQ_PUT:    if (!hit && !evict) count_d = count_q + CntW'(1);
      lkvc_pkg::REQ_REMOVE: if (hit) count_d = count_q - CntW'(1);
      lkvc_pkg::REQ_CLEAR:  count_d = '0;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lkvc_pkg::ST_IDLE;
      cap_q   <= CntW'(MAX_ENTRIES);
      count_q <= '0;
      done_q  <= 1'b0;
      req_q   <= lkvc_pkg::REQ_GET;
    end else begin
      state_q <= state_d;
      done_q  <= (state_q == lkvc_pkg::ST_UPD);
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
      if (state_q == lkvc_pkg::ST_IDLE && start) begin
        req_q <= lkvc_pkg::req_e'(req_type_i);
      end
      if (state_q == lkvc_pkg::ST_UPD) begin
        count_q <= count_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == lkvc_pkg::ST_IDLE && start) begin
      key_q <= key_i;
      val_q <= value_in_i;
    end
    if (state_q == lkvc_pkg::ST_UPD) begin
      found_q <= hit & ((req_q == lkvc_pkg::REQ_GET) | (req_q == lkvc_pkg::REQ_REMOVE));
      vout_q  <= (hit && req_q == lkvc_pkg::REQ_GET) ? c_hv[0] : '0;
    end
  end

  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
    logic [KEY_BITS-1:0]   p_key, n_key;
    logic [VALUE_BITS-1:0] p_val, n_val, hv_in;
    logic                  p_valid, n_valid, pre_in, suf_in;

    if (i == 0) begin : g_head
      assign p_key   = key_q;
      assign p_val   = head_value;
      assign p_valid = 1'b1;
      assign pre_in  = 1'b0;
    end else begin : g_mid
      assign p_key   = c_key[i-1];
      assign p_val   = c_val[i-1];
      assign p_valid = c_valid[i-1];
      assign pre_in  = c_pre[i-1];
    end

    if (i == MAX_ENTRIES - 1) begin : g_tail
      assign n_key   = '0;
      assign n_val   = '0;
      assign n_valid = 1'b0;
      assign suf_in  = 1'b0;
      assign hv_in   = '0;
    end else begin : g_body
      assign n_key   = c_key[i+1];
      assign n_val   = c_val[i+1];
      assign n_valid = c_valid[i+1];
      assign suf_in  = c_suf[i+1];
      assign hv_in   = c_hv[i+1];
    end

    lkvc_cell #(
      .KEY_BITS  (KEY_BITS),
      .VALUE_BITS(VALUE_BITS)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctl_i       (ctl),
      .req_key_i   (key_q),
      .prev_key_i  (p_key),
      .prev_value_i(p_val),
      .prev_valid_i(p_valid),
      .next_key_i  (n_key),
      .next_value_i(n_val),
      .next_valid_i(n_valid),
      .pre_i       (pre_in),
      .suf_i       (suf_in),
      .hv_i        (hv_in),
      .key_o       (c_key[i]),
      .value_o     (c_val[i]),
      .valid_o     (c_valid[i]),
      .pre_o       (c_pre[i]),
      .suf_o       (c_suf[i]),
      .hv_o        (c_hv[i])
    );
  end

  a_count_matches_cells: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == lkvc_pkg::ST_IDLE) |-> ($countones(c_valid) == 32'(count_q)))
    else $error("entry count disagrees with valid cells");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(MAX_ENTRIES))
    else $error("entry count beyond capacity");

  a_done_after_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(state_q == lkvc_pkg::ST_UPD))
    else $error("result strobe without an update cycle");

  a_start_runs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == lkvc_pkg::ST_IDLE && start) |=> ##2 done_o)
    else $error("accepted request gave no result");

endmodule
